// ===== rtl/core/spst_pkg.sv =====
package spst_pkg;

  localparam int OP_W      = 2;
  localparam int PATH_W    = 10;
  localparam int ROW_W     = 10;
  localparam int IDX_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 9;
  localparam int KEY_W     = PATH_W + ROW_W;
  localparam int TDATA_W   = 32;

  localparam int CAPACITY_DEF = 256;
  localparam int GROUP_SIZE   = 16;

  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE     = 2'd1;
  localparam logic [OP_W-1:0] OP_READ       = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_ALIAS = 2'd3;
  localparam int              OP_READ_BIT   = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_INVALID   = 3'd2,
    ST_FULL      = 3'd3,
    ST_DELETED   = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_READOK    = 3'd6,
    ST_BEYOND    = 3'd7
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  typedef struct packed {
    logic eq;
    logic hit;
  } cell_flag_t;

  typedef struct packed {
    logic             eq;
    logic [KEY_W-1:0] key;
  } grp_sum_t;

endpackage

// ===== rtl/core/sorted_pair_set_table.sv =====
// channel  dir  tdata fields (low bit up)
// s_axis   in   op[1:0] path_value[11:2] row_value[21:12] read_index[29:22]
// m_axis   out  status[2:0] entry_path[12:3] entry_row[22:13] entry_count[31:23]
//
// One beat in, one beat out; the input beat is registered, the cell row's compare
// is registered in the 16-wide group OR register (S_CMP), and apply (S_APPLY)
// registers the result beat.
// A new input beat is taken only once the last one has been applied; apply waits while a
// result beat is stalled.
// rst clears the count; cell contents need no reset.
// A stalled result holds; a new input beat may be taken while it waits.
module sorted_pair_set_table import spst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // op, path_value, row_value, read_index
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // status, entry_path, entry_row, entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t             state;
  logic [OP_W-1:0]    op;
  logic [PATH_W-1:0]  path;
  logic [ROW_W-1:0]   row;
  logic [IDX_W-1:0]   rd_index;
  logic [CW-1:0]      count;
  logic               out_valid;
  logic [TDATA_W-1:0] out_data;

  logic [KEY_W-1:0]   probe;
  cell_cmd_t          cmd;
  logic [KEY_W-1:0]   key_arr [CAPACITY];
  logic               lt_arr  [CAPACITY];
  cell_flag_t         flag_arr[CAPACITY];
  logic [KEY_W-1:0]   key_pad [NG*GROUP_SIZE];
  cell_flag_t         flag_pad[NG*GROUP_SIZE];
  grp_sum_t           grp     [NG];

  logic               dup;
  logic [KEY_W-1:0]   rd_key;
  logic               go;
  status_t            status;
  logic [CW-1:0]      count_next;
  logic               do_ins;
  logic               do_del;
  logic [KEY_W-1:0]   out_key;

  assign probe         = {path, row};
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      spst_cell #(.CAPACITY(CAPACITY), .IDX(gi)) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .probe    (probe),
        .rd_index (rd_index),
        .count    (count),
        .prev_key ((gi == 0) ? probe : key_arr[(gi == 0) ? 0 : gi-1]),
        .next_key ((gi == CAPACITY-1) ? key_arr[gi] : key_arr[(gi == CAPACITY-1) ? gi : gi+1]),
        .prev_lt  ((gi == 0) ? 1'b1 : lt_arr[(gi == 0) ? 0 : gi-1]),
        .key      (key_arr[gi]),
        .lt       (lt_arr[gi]),
        .flag     (flag_arr[gi])
      );
    end
    for (gi = 0; gi < NG*GROUP_SIZE; gi++) begin : g_pad
      if (gi < CAPACITY) begin : g_real
        assign key_pad[gi]  = key_arr[gi];
        assign flag_pad[gi] = flag_arr[gi];
      end else begin : g_zero
        assign key_pad[gi]  = '0;
        assign flag_pad[gi] = '0;
      end
    end
    for (gi = 0; gi < NG; gi++) begin : g_grp
      spst_group #(.SIZE(GROUP_SIZE)) u_group (
        .clk   (clk),
        .flags (flag_pad[gi*GROUP_SIZE +: GROUP_SIZE]),
        .keys  (key_pad[gi*GROUP_SIZE +: GROUP_SIZE]),
        .sum   (grp[gi])
      );
    end
  endgenerate

  always_comb begin
    dup    = 1'b0;
    rd_key = '0;
    for (int g = 0; g < NG; g++) begin
      dup    = dup | grp[g].eq;
      rd_key = rd_key | grp[g].key;
    end
  end

  assign go = (state == S_APPLY) && (!out_valid || m_axis_tready);

  always_comb begin
    status     = ST_NOTFOUND;
    count_next = count;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    out_key    = '0;
    if (op[OP_READ_BIT]) begin
      if (32'(rd_index) < 32'(count)) begin
        status  = ST_READOK;
        out_key = rd_key;
      end else begin
        status = ST_BEYOND;
      end
    end else if (op == OP_INSERT) begin
      if (path == '0) begin
        status = ST_INVALID;
      end else if (dup) begin
        status = ST_DUPLICATE;
      end else if (count >= CW'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        status     = ST_INSERTED;
        do_ins     = 1'b1;
        count_next = count + CW'(1);
      end
    end else begin
      if (path != '0 && dup) begin
        status     = ST_DELETED;
        do_del     = 1'b1;
        count_next = count - CW'(1);
      end
    end
  end

  assign cmd.ins = go && do_ins;
  assign cmd.del = go && do_del;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (go) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op       <= s_axis_tdata[1:0];
      path     <= s_axis_tdata[11:2];
      row      <= s_axis_tdata[21:12];
      rd_index <= s_axis_tdata[29:22];
    end
    if (go) begin
      out_data <= {CNT_OUT_W'(count_next), out_key[ROW_W-1:0], out_key[KEY_W-1:ROW_W],
                   status};
    end
  end

endmodule

// ===== rtl/core/spst_cell.sv =====
module spst_cell import spst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                              clk,
  input  cell_cmd_t                         cmd,
  input  logic [KEY_W-1:0]                  probe,
  input  logic [IDX_W-1:0]                  rd_index,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  logic [KEY_W-1:0]                  prev_key,
  input  logic [KEY_W-1:0]                  next_key,
  input  logic                              prev_lt,
  output logic [KEY_W-1:0]                  key,
  output logic                              lt,
  output cell_flag_t                        flag
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CIW = (IW > IDX_W) ? IW : IDX_W;

  logic valid;

  assign valid    = CW'(IDX) < count;
  assign lt       = valid && (key < probe);
  assign flag.eq  = valid && (key == probe);
  assign flag.hit = valid && (CIW'(rd_index) == CIW'(IDX));

  // insert: entries above the slot move up one; delete: entries from the slot move down
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      key <= prev_lt ? probe : prev_key;
    end else if (cmd.del && !lt) begin
      key <= next_key;
    end
  end

endmodule

// ===== rtl/core/spst_group.sv =====
module spst_group import spst_pkg::*; #(
  parameter int SIZE = GROUP_SIZE
) (
  input  logic             clk,
  input  cell_flag_t       flags [SIZE],
  input  logic [KEY_W-1:0] keys  [SIZE],
  output grp_sum_t         sum
);

  grp_sum_t acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < SIZE; i++) begin
      acc.eq  = acc.eq | flags[i].eq;
      acc.key = acc.key | (flags[i].hit ? keys[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    sum <= acc;
  end

endmodule

// ===== rtl/core/spst_check.sv =====
module spst_check import spst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] st;

  assign st = m_axis_tdata[2:0];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before item finished");

  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st != ST_READOK |-> m_axis_tdata[22:3] == '0)
    else $error("entry fields nonzero outside a read");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == ST_FULL |-> m_axis_tdata[31:23] == CNT_OUT_W'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind sorted_pair_set_table spst_check #(.CAPACITY(CAPACITY)) u_spst_check (.*);
